// ===== rtl/cau_pkg.sv =====
// shared types, constants and codes of the complex arithmetic unit
package cau_pkg;

	localparam int DW  = 32;
	localparam int FB  = 16;
	localparam int PW  = 2 * DW;
	localparam int MW  = 2 * DW + 1;
	localparam int RW  = 3 * DW + 1;
	localparam int QD  = 4;
	localparam int QAW = $clog2(QD);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} cau_op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIVZ = 2'd2
	} cau_status_t;

	typedef struct packed {
		cau_op_t               opcode;
		logic signed [DW-1:0]  x_real;
		logic signed [DW-1:0]  x_imag;
		logic signed [DW-1:0]  y_real;
		logic signed [DW-1:0]  y_imag;
	} cau_in_t;

	typedef struct packed {
		logic signed [DW-1:0]  res_real;
		logic signed [DW-1:0]  res_imag;
		cau_status_t           status;
	} cau_out_t;

	typedef struct packed {
		cau_op_t               op;
		logic                  divz;
		logic signed [DW-1:0]  xr;
		logic signed [DW-1:0]  xi;
		logic signed [DW-1:0]  yr;
		logic signed [DW-1:0]  yi;
	} cau_cmd_t;

	typedef struct packed {
		logic           is_div;
		logic           divz;
		logic           neg_re;
		logic           neg_im;
		logic [MW-1:0]  mag_re;
		logic [MW-1:0]  mag_im;
	} cau_tag_t;

endpackage

// ===== rtl/cau_front.sv =====
// front end: accepts and classifies transactions into a short command queue
module cau_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cau_pkg::cau_in_t  in_data,
	output logic              full,
	output cau_pkg::cau_cmd_t head,
	output logic              head_valid,
	input  logic              deq
);
	import cau_pkg::*;

	cau_cmd_t        mem_q [QD];
	logic [QAW-1:0]  wr_q;
	logic [QAW-1:0]  rd_q;
	logic [QAW:0]    cnt_q;
	cau_cmd_t        cmd;
	logic            wr_en;
	logic            rd_en;

	always_comb begin
		cmd.op   = in_data.opcode;
		cmd.xr   = in_data.x_real;
		cmd.xi   = in_data.x_imag;
		cmd.yr   = in_data.y_real;
		cmd.yi   = in_data.y_imag;
		cmd.divz = (in_data.opcode == OP_DIV) && (in_data.y_real == '0)
			&& (in_data.y_imag == '0);
	end

	assign full       = (cnt_q == (QAW+1)'(QD));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign wr_en      = push && !full;
	assign rd_en      = deq && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= cmd;
		end
	end

endmodule

// ===== rtl/cau_div.sv =====
// pipelined restoring divider, one quotient bit per stage for both parts
module cau_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [cau_pkg::RW-1:0]    num_re,
	input  logic [cau_pkg::RW-1:0]    num_im,
	input  logic [cau_pkg::PW-1:0]    den,
	input  cau_pkg::cau_tag_t         in_tag,
	output logic                      out_valid,
	output logic [cau_pkg::DW:0]      q_re,
	output logic [cau_pkg::DW:0]      q_im,
	output cau_pkg::cau_tag_t         out_tag
);
	import cau_pkg::*;

	logic           v_sn     [DW+1];
	logic [RW-1:0]  rem_re_sn [DW+1];
	logic [RW-1:0]  rem_im_sn [DW+1];
	logic [PW-1:0]  den_sn   [DW+1];
	logic [DW:0]    q_re_sn  [DW+1];
	logic [DW:0]    q_im_sn  [DW+1];
	cau_tag_t       tag_sn   [DW+1];
	logic [RW-1:0]  den_top;
	logic           big_re;
	logic           big_im;

	// quotient of at least 2^DW always saturates
	assign den_top = RW'(den) << DW;
	assign big_re  = (num_re >= den_top);
	assign big_im  = (num_im >= den_top);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn[0] <= 1'b0;
		end else if (en) begin
			v_sn[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_re_sn[0] <= num_re;
			rem_im_sn[0] <= num_im;
			den_sn[0]    <= den;
			q_re_sn[0]   <= {big_re, {DW{1'b0}}};
			q_im_sn[0]   <= {big_im, {DW{1'b0}}};
			tag_sn[0]    <= in_tag;
		end
	end

	for (genvar k = 1; k <= DW; k++) begin : g_stage
		logic [RW-1:0] dsh;
		logic          ge_re;
		logic          ge_im;
		logic [DW:0]   qre_n;
		logic [DW:0]   qim_n;

		assign dsh   = RW'(den_sn[k-1]) << (DW - k);
		assign ge_re = (rem_re_sn[k-1] >= dsh);
		assign ge_im = (rem_im_sn[k-1] >= dsh);
		assign qre_n = q_re_sn[k-1] | ((DW+1)'(ge_re) << (DW - k));
		assign qim_n = q_im_sn[k-1] | ((DW+1)'(ge_im) << (DW - k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[k] <= 1'b0;
			end else if (en) begin
				v_sn[k] <= v_sn[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_re_sn[k]         <= ge_re ? rem_re_sn[k-1] - dsh : rem_re_sn[k-1];
				rem_im_sn[k]         <= ge_im ? rem_im_sn[k-1] - dsh : rem_im_sn[k-1];
				den_sn[k]            <= den_sn[k-1];
				q_re_sn[k]           <= qre_n;
				q_im_sn[k]           <= qim_n;
				tag_sn[k]            <= tag_sn[k-1];
			end
		end
	end

	assign out_valid = v_sn[DW];
	assign q_re      = q_re_sn[DW];
	assign q_im      = q_im_sn[DW];
	assign out_tag   = tag_sn[DW];

endmodule

// ===== rtl/cau_back.sv =====
// back end: products, sums, magnitudes, divider and saturating output stage
module cau_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cau_pkg::cau_cmd_t  head,
	input  logic               head_valid,
	output logic               deq,
	output logic               empty,
	input  logic               pop,
	output cau_pkg::cau_out_t  out_data
);
	import cau_pkg::*;

	function automatic logic [DW:0] sat(input logic neg, input logic [MW-1:0] mag);
		logic [MW-1:0] lim;
		logic [DW:0]   r;
		lim = MW'(1) << (DW - 1);
		if (!neg && mag >= lim) begin
			r = {1'b1, 1'b0, {(DW-1){1'b1}}};
		end else if (neg && mag > lim) begin
			r = {1'b1, 1'b1, {(DW-1){1'b0}}};
		end else if (neg) begin
			r = {1'b0, ~mag[DW-1:0] + 1'b1};
		end else begin
			r = {1'b0, mag[DW-1:0]};
		end
		return r;
	endfunction

	logic                  en;
	logic                  v_out_q;

	// stage 1: products and plain sums
	logic                  v_s1;
	cau_op_t               op_s1;
	logic                  divz_s1;
	logic signed [PW-1:0]  prr_s1, pii_s1, pri_s1, pir_s1, drr_s1, dii_s1;
	logic signed [DW:0]    sre_s1, sim_s1;
	logic signed [PW-1:0]  prr_c, pii_c, pri_c, pir_c, drr_c, dii_c;
	logic signed [DW:0]    xr_e, xi_e, yr_e, yi_e;

	// stage 2: combined parts
	logic                  v_s2;
	cau_op_t               op_s2;
	logic                  divz_s2;
	logic signed [MW-1:0]  re_s2, im_s2;
	logic [PW-1:0]         den_s2;
	logic signed [MW-1:0]  re_c, im_c;

	// stage 3: sign and magnitude
	logic                  v_s3;
	cau_tag_t              tag_s3;
	logic [RW-1:0]         num_re_s3, num_im_s3;
	logic [PW-1:0]         den_s3;
	logic [MW-1:0]         mag_re_c, mag_im_c;

	logic                  dv_valid;
	logic [DW:0]           q_re, q_im;
	cau_tag_t              dv_tag;
	logic [MW-1:0]         fin_re, fin_im;
	logic [DW:0]           sat_re, sat_im;
	cau_out_t              out_q;

	assign en    = !(v_out_q && !pop);
	assign deq   = en;
	assign empty = !v_out_q;

	assign xr_e = {head.xr[DW-1], head.xr};
	assign xi_e = {head.xi[DW-1], head.xi};
	assign yr_e = {head.yr[DW-1], head.yr};
	assign yi_e = {head.yi[DW-1], head.yi};

	assign prr_c = $signed(head.xr) * $signed(head.yr);
	assign pii_c = $signed(head.xi) * $signed(head.yi);
	assign pri_c = $signed(head.xr) * $signed(head.yi);
	assign pir_c = $signed(head.xi) * $signed(head.yr);
	assign drr_c = $signed(head.yr) * $signed(head.yr);
	assign dii_c = $signed(head.yi) * $signed(head.yi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else if (en) begin
			v_s1    <= head_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_out_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= head.op;
			divz_s1 <= head.divz;
			prr_s1  <= prr_c;
			pii_s1  <= pii_c;
			pri_s1  <= pri_c;
			pir_s1  <= pir_c;
			drr_s1  <= drr_c;
			dii_s1  <= dii_c;
			sre_s1  <= (head.op == OP_SUB) ? xr_e - yr_e : xr_e + yr_e;
			sim_s1  <= (head.op == OP_SUB) ? xi_e - yi_e : xi_e + yi_e;
		end
	end

	always_comb begin
		case (op_s1)
			OP_MUL: begin
				re_c = MW'(prr_s1) - MW'(pii_s1);
				im_c = MW'(pri_s1) + MW'(pir_s1);
			end
			OP_DIV: begin
				re_c = MW'(prr_s1) + MW'(pii_s1);
				im_c = MW'(pir_s1) - MW'(pri_s1);
			end
			default: begin
				re_c = MW'(sre_s1);
				im_c = MW'(sim_s1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= op_s1;
			divz_s2 <= divz_s1;
			re_s2   <= re_c;
			im_s2   <= im_c;
			den_s2  <= PW'(drr_s1 + dii_s1);
		end
	end

	assign mag_re_c = re_s2[MW-1] ? MW'(-re_s2) : MW'(re_s2);
	assign mag_im_c = im_s2[MW-1] ? MW'(-im_s2) : MW'(im_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3.is_div <= (op_s2 == OP_DIV);
			tag_s3.divz   <= divz_s2;
			tag_s3.neg_re <= re_s2[MW-1];
			tag_s3.neg_im <= im_s2[MW-1];
			tag_s3.mag_re <= (op_s2 == OP_MUL) ? mag_re_c >> FB : mag_re_c;
			tag_s3.mag_im <= (op_s2 == OP_MUL) ? mag_im_c >> FB : mag_im_c;
			num_re_s3     <= RW'(mag_re_c) << FB;
			num_im_s3     <= RW'(mag_im_c) << FB;
			den_s3        <= den_s2;
		end
	end

	cau_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num_re    (num_re_s3),
		.num_im    (num_im_s3),
		.den       (den_s3),
		.in_tag    (tag_s3),
		.out_valid (dv_valid),
		.q_re      (q_re),
		.q_im      (q_im),
		.out_tag   (dv_tag)
	);

	assign fin_re = dv_tag.is_div ? MW'(q_re) : dv_tag.mag_re;
	assign fin_im = dv_tag.is_div ? MW'(q_im) : dv_tag.mag_im;
	assign sat_re = sat(dv_tag.neg_re, fin_re);
	assign sat_im = sat(dv_tag.neg_im, fin_im);

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_tag.divz) begin
				out_q.res_real <= '0;
				out_q.res_imag <= '0;
				out_q.status   <= ST_DIVZ;
			end else begin
				out_q.res_real <= sat_re[DW-1:0];
				out_q.res_imag <= sat_im[DW-1:0];
				out_q.status   <= (sat_re[DW] || sat_im[DW]) ? ST_OVF : ST_OK;
			end
		end
	end

	assign out_data = out_q;

endmodule

// ===== rtl/complex_arith_unit.sv =====
// top level of the complex arithmetic unit
//
// Both sides behave as queues. A transaction is written with push while
// full is low; it carries an opcode (add, subtract, multiply, divide) and
// two complex Q16.16 operands. Results are read with pop while empty is
// low; each carries the real and imaginary Q16.16 parts and a status
// (ok, overflow saturated, divide by zero).
// A front end classifies each transaction into a four-entry command queue;
// the back end pulls one command per cycle, unless the output holds, into a
// 37-stage pipeline: products, sums, magnitudes, a 33-stage restoring
// divider (one quotient bit per stage) and a saturating output register.
// All operations take the same path, so results leave in order.
// Throughput is one transaction per cycle while the output is not stalled.
// Reset clears the queue and all pipeline valid bits; no result is shown.
// While a result waits with pop low the whole back end holds; the command
// queue keeps taking transactions until it fills, then full goes high.
module complex_arith_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  cau_pkg::cau_in_t  in_data,
	output logic              empty,
	input  logic              pop,
	output cau_pkg::cau_out_t out_data
);
	import cau_pkg::*;

	cau_cmd_t head;
	logic     head_valid;
	logic     deq;

	cau_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.in_data    (in_data),
		.full       (full),
		.head       (head),
		.head_valid (head_valid),
		.deq        (deq)
	);

	cau_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.deq        (deq),
		.empty      (empty),
		.pop        (pop),
		.out_data   (out_data)
	);

endmodule

// ===== rtl/cau_check.sv =====
// port checker of the complex arithmetic unit and its bind
module cau_check (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input cau_pkg::cau_in_t  in_data,
	input logic              empty,
	input logic              pop,
	input cau_pkg::cau_out_t out_data
);
	import cau_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(out_data))
		else $error("result changed while stalled");

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.status == ST_DIVZ) |->
		(out_data.res_real == '0 && out_data.res_imag == '0))
		else $error("divide by zero result not zero");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.status == ST_OVF) |->
		(out_data.res_real == {1'b0, {(DW-1){1'b1}}}
		|| out_data.res_real == {1'b1, {(DW-1){1'b0}}}
		|| out_data.res_imag == {1'b0, {(DW-1){1'b1}}}
		|| out_data.res_imag == {1'b1, {(DW-1){1'b0}}}))
		else $error("overflow status without saturated part");

endmodule

bind complex_arith_unit cau_check u_cau_check (.*);
